### hw/rtl/positional_list_engine_defines.svh
// Assertion macros for the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PLE_ASSERT_NOW(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("list engine check failed");

// A condition that must hold in the cycle after a trigger.
`define PLE_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("list engine check failed");

`endif

### hw/rtl/ple_pkg.sv
`timescale 1ns / 1ps
package ple_pkg;

	localparam int CAPACITY = 128;
	localparam int DATA_W = 32;
	localparam int POS_W = 8;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int GRP_SIZE = 8;
	localparam int NGRP = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_WRITE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic ins;
		logic del;
		logic wr;
		logic rd;
		logic [CNT_W-1:0] pos;
		logic [DATA_W-1:0] val;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [POS_W-1:0] count_now;
	} res_t;

endpackage

### hw/rtl/positional_list_engine.sv
`timescale 1ns / 1ps
// Each input transaction passes through the vld_s1, vld_s2 and out_vld_q registers to its result.
// Only one transaction is in flight at a time: a new input is taken the cycle
// after the pending result is taken.
// The cell row shifts all affected entries in parallel; the read path is a two-level OR tree.
// Reset clears the count and the control flags; entries hold no reset value.
`include "positional_list_engine_defines.svh"
module positional_list_engine
	import ple_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [39:0] s_axis_tdata, // position [7:0], value [39:8]
	input  logic [1:0] s_axis_tuser, // operation [1:0]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [39:0] m_axis_tdata, // read_value [31:0], count_now [39:32]
	output logic [1:0] m_axis_tuser // status [1:0]
);

	logic busy_q;
	logic [CNT_W-1:0] count_q;
	logic acc;
	logic out_done;

	cmd_t dec_cmd;
	res_t dec_res;
	logic [CNT_W-1:0] dec_count;

	cmd_t cmd_s1;
	res_t res_s1;
	logic vld_s1;
	res_t res_s2;
	logic vld_s2;
	logic [DATA_W-1:0] grp_s2 [NGRP];

	logic out_vld_q;
	res_t out_res_q;
	logic [DATA_W-1:0] out_data_q;

	logic [DATA_W-1:0] cell_q [CAPACITY];
	logic [DATA_W-1:0] rd_pad [NGRP*GRP_SIZE];
	logic [DATA_W-1:0] grp_or [NGRP];
	logic [DATA_W-1:0] rd_or;

	assign s_axis_tready = !busy_q;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign out_done = out_vld_q && m_axis_tready;

	ple_decode u_decode (
		.operation(s_axis_tuser),
		.position(s_axis_tdata[POS_W-1:0]),
		.value(s_axis_tdata[POS_W+DATA_W-1:POS_W]),
		.count(count_q),
		.cmd(dec_cmd),
		.res(dec_res),
		.count_next(dec_count)
	);

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic [DATA_W-1:0] lower;
			logic [DATA_W-1:0] upper;
			if (i == 0) begin : g_first
				assign lower = '0;
			end else begin : g_mid_lo
				assign lower = cell_q[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign upper = '0;
			end else begin : g_mid_hi
				assign upper = cell_q[i+1];
			end
			ple_cell u_cell (
				.clk(clk),
				.cmd_vld(vld_s1),
				.cmd(cmd_s1),
				.idx(CNT_W'(i)),
				.lower(lower),
				.upper(upper),
				.entry(cell_q[i]),
				.rd_data(rd_pad[i])
			);
		end
		for (i = CAPACITY; i < NGRP * GRP_SIZE; i++) begin : g_pad
			assign rd_pad[i] = '0;
		end
	endgenerate

	// Only the addressed cell drives a nonzero word, so OR works as the read mux.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				grp_or[g] = grp_or[g] | rd_pad[g*GRP_SIZE+k];
			end
		end
	end

	always_comb begin
		rd_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_or = rd_or | grp_s2[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			count_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			if (acc) begin
				busy_q <= 1'b1;
				count_q <= dec_count;
			end else if (out_done) begin
				busy_q <= 1'b0;
			end
			if (vld_s2) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1 <= dec_cmd;
			res_s1 <= dec_res;
		end
		if (vld_s1) begin
			grp_s2 <= grp_or;
			res_s2 <= res_s1;
		end
		if (vld_s2) begin
			out_res_q <= res_s2;
			out_data_q <= rd_or;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser = out_res_q.status;
	assign m_axis_tdata = {out_res_q.count_now, out_data_q};

	`PLE_ASSERT_NOW(a_count_range, count_q <= CNT_W'(CAPACITY))
	`PLE_ASSERT_NOW(a_one_in_flight, $countones({vld_s1, vld_s2, out_vld_q}) <= 1)
	`PLE_ASSERT_NOW(a_out_busy, !out_vld_q || busy_q)
	`PLE_ASSERT_NEXT(a_count_hold, !acc, $stable(count_q))
	`PLE_ASSERT_NOW(a_fail_no_data, !out_vld_q || out_res_q.status == ST_OK || out_data_q == '0)

endmodule

### hw/rtl/ple_cell.sv
`timescale 1ns / 1ps
module ple_cell
	import ple_pkg::*;
(
	input  logic clk,
	input  logic cmd_vld,
	input  cmd_t cmd,
	input  logic [CNT_W-1:0] idx,
	input  logic [DATA_W-1:0] lower,
	input  logic [DATA_W-1:0] upper,
	output logic [DATA_W-1:0] entry,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] entry_q;
	logic hit;

	assign hit = (idx == cmd.pos);

	// Ins pulls from below, del from above; ins/wr load cmd.val at pos.
	always_ff @(posedge clk) begin
		if (cmd_vld) begin
			if (cmd.ins && (idx > cmd.pos)) begin
				entry_q <= lower;
			end else if ((cmd.ins || cmd.wr) && hit) begin
				entry_q <= cmd.val;
			end else if (cmd.del && (idx >= cmd.pos)) begin
				entry_q <= upper;
			end
		end
	end

	assign entry = entry_q;
	assign rd_data = (cmd_vld && cmd.rd && hit) ? entry_q : '0;

endmodule

### hw/rtl/ple_decode.sv
`timescale 1ns / 1ps
module ple_decode
	import ple_pkg::*;
(
	input  logic [1:0] operation,
	input  logic [POS_W-1:0] position,
	input  logic [DATA_W-1:0] value,
	input  logic [CNT_W-1:0] count,
	output cmd_t cmd,
	output res_t res,
	output logic [CNT_W-1:0] count_next
);

	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] cnt_next_w;

	assign pos_w = CMP_W'(position);
	assign cnt_w = CMP_W'(count);

	always_comb begin
		cmd = '0;
		cmd.pos = pos_w[CNT_W-1:0];
		cmd.val = value;
		res.status = ST_OK;
		count_next = count;
		unique case (operation)
			OP_INSERT: begin
				if (count == CNT_W'(CAPACITY)) begin
					res.status = ST_OVERFLOW;
				end else if (pos_w > cnt_w) begin
					res.status = ST_INVALID;
				end else begin
					cmd.ins = 1'b1;
					count_next = count + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (pos_w >= cnt_w) begin
					res.status = ST_INVALID;
				end else begin
					cmd.del = 1'b1;
					count_next = count - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (pos_w >= cnt_w) begin
					res.status = ST_INVALID;
				end else begin
					cmd.rd = 1'b1;
				end
			end
			OP_WRITE: begin
				if (pos_w >= cnt_w) begin
					res.status = ST_INVALID;
				end else begin
					cmd.wr = 1'b1;
				end
			end
			default: begin
				res.status = ST_INVALID;
			end
		endcase
		cnt_next_w = CMP_W'(count_next);
		res.count_now = cnt_next_w[POS_W-1:0];
	end

endmodule

### test/positional_list_engine_tb.sv
`timescale 1ns / 1ps
module positional_list_engine_tb;
	import ple_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 250;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] read_value;
		logic [7:0] count_now;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata = '0; // position [7:0], value [39:8]
	logic [1:0] s_axis_tuser = '0; // operation [1:0]
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata; // read_value [31:0], count_now [39:32]
	logic [1:0] m_axis_tuser; // status [1:0]

	// Shadow copy of the list and its length.
	logic [31:0] list_vals [CAPACITY];
	int list_len = 0;

	list_result_t expected_results [$];
	int fail_count = 0;
	int ops_sent = 0;
	int results_checked = 0;
	int full_rejects = 0;
	int bad_positions = 0;
	int burst_left = 0;
	int cycles = 0;
	bit hold_req = 1'b0;

	positional_list_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic list_result_t apply_list_op(logic [1:0] op, logic [7:0] pos,
			logic [31:0] val);
		list_result_t r;
		int i;
		r.status = ST_OK;
		r.read_value = '0;
		if (op == OP_INSERT) begin
			if (list_len >= CAPACITY) begin
				r.status = ST_OVERFLOW;
			end else if (int'(pos) > list_len) begin
				r.status = ST_INVALID;
			end else begin
				for (i = list_len; i > int'(pos); i--)
					list_vals[i] = list_vals[i - 1];
				list_vals[pos] = val;
				list_len++;
			end
		end else if (int'(pos) >= list_len) begin
			r.status = ST_INVALID;
		end else begin
			case (op)
				OP_DELETE: begin
					for (i = int'(pos); i < list_len - 1; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
				end
				OP_READ: r.read_value = list_vals[pos];
				OP_WRITE: list_vals[pos] = val;
				default: ;
			endcase
		end
		r.count_now = list_len[7:0];
		return r;
	endfunction

	// Offers one operation, keeping the sender in bursts with random gaps between.
	task automatic send_op(logic [1:0] op, logic [7:0] pos, logic [31:0] val);
		list_result_t r;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {val, pos};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		r = apply_list_op(op, pos, val);
		if (r.status == ST_OVERFLOW)
			full_rejects++;
		if (r.status == ST_INVALID)
			bad_positions++;
		expected_results.push_back(r);
		ops_sent++;
		burst_left--;
	endtask

	// Stops offering until every outstanding result has been taken.
	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// Mostly legal positions for the current length, with some anywhere in the field.
	function automatic logic [7:0] pick_position(logic [1:0] op);
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		if (op == OP_INSERT)
			return (list_len >= CAPACITY) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, list_len));
		if (list_len == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, list_len - 1));
	endfunction

	function automatic logic [1:0] pick_op();
		int w;
		w = $urandom_range(0, 99);
		if (w < 35)
			return OP_INSERT;
		if (w < 60)
			return OP_DELETE;
		if (w < 85)
			return OP_READ;
		return OP_WRITE;
	endfunction

	task automatic send_random_ops(int n);
		logic [1:0] op;
		repeat (n) begin
			op = pick_op();
			send_op(op, pick_position(op), $urandom());
		end
	endtask

	task automatic test_empty_list();
		send_op(OP_READ, 8'd0, 32'h0);
		send_op(OP_DELETE, 8'd0, 32'h0);
		send_op(OP_WRITE, 8'd0, 32'h5a5a_a5a5);
		send_op(OP_INSERT, 8'd1, 32'h1111_1111);
		send_op(OP_INSERT, 8'd255, 32'h2222_2222);
		send_op(OP_DELETE, 8'd255, 32'h0);
	endtask

	task automatic test_basic_ops();
		send_op(OP_INSERT, 8'd0, 32'h7fff_ffff);
		send_op(OP_INSERT, 8'd1, 32'h8000_0000);
		send_op(OP_INSERT, 8'd1, 32'hffff_ffff);
		send_op(OP_INSERT, 8'd0, 32'h0000_0000);
		for (int p = 0; p < 4; p++)
			send_op(OP_READ, 8'(p), 32'h0);
		send_op(OP_WRITE, 8'd2, 32'h1234_5678);
		send_op(OP_READ, 8'd2, 32'h0);
		// Position equal to the length is one past the end for everything but insert.
		send_op(OP_READ, 8'd4, 32'h0);
		send_op(OP_WRITE, 8'd4, 32'hdead_beef);
		send_op(OP_DELETE, 8'd3, 32'h0);
		send_op(OP_DELETE, 8'd0, 32'h0);
		send_op(OP_READ, 8'd0, 32'h0);
		send_op(OP_READ, 8'd1, 32'h0);
	endtask

	task automatic test_fill_to_capacity();
		while (list_len < CAPACITY)
			send_op(OP_INSERT, 8'($urandom_range(0, list_len)), $urandom());
		send_op(OP_INSERT, 8'd0, $urandom());
		send_op(OP_INSERT, 8'(CAPACITY), $urandom());
		send_op(OP_INSERT, 8'd255, $urandom());
		send_op(OP_READ, 8'(CAPACITY - 1), 32'h0);
		send_op(OP_READ, 8'(CAPACITY), 32'h0);
		send_op(OP_WRITE, 8'(CAPACITY - 1), $urandom());
		send_op(OP_READ, 8'(CAPACITY - 1), 32'h0);
	endtask

	task automatic test_receiver_backpressure();
		hold_req = 1'b1;
		send_random_ops(30);
	endtask

	task automatic test_drain_pause();
		wait_for_drain();
		send_random_ops(20);
	endtask

	task automatic test_empty_out();
		while (list_len > 0) begin
			if ($urandom_range(0, 4) == 0)
				send_op(OP_READ, 8'($urandom_range(0, list_len - 1)), 32'h0);
			send_op(OP_DELETE, 8'($urandom_range(0, list_len - 1)), 32'h0);
		end
		send_op(OP_DELETE, 8'd0, 32'h0);
		send_op(OP_INSERT, 8'd0, $urandom());
		send_op(OP_READ, 8'd0, 32'h0);
	endtask

	// Receiver: checks each accepted result and stalls on a changing pattern.
	initial begin
		list_result_t exp_r;
		list_result_t got_r;
		int hold_left;
		int pattern_left;
		int stall_mode;
		hold_left = 0;
		pattern_left = 0;
		stall_mode = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got_r.status = m_axis_tuser;
				got_r.read_value = m_axis_tdata[31:0];
				got_r.count_now = m_axis_tdata[39:32];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, actual status %0d value %h count %0d",
						$time, got_r.status, got_r.read_value, got_r.count_now);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					results_checked++;
					if (got_r.status !== exp_r.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_r.status, got_r.status);
						fail_count++;
					end
					if (got_r.read_value !== exp_r.read_value) begin
						$display("%0t: read_value expected %h actual %h",
							$time, exp_r.read_value, got_r.read_value);
						fail_count++;
					end
					if (got_r.count_now !== exp_r.count_now) begin
						$display("%0t: count_now expected %0d actual %0d",
							$time, exp_r.count_now, got_r.count_now);
						fail_count++;
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (pattern_left == 0) begin
				pattern_left = $urandom_range(8, 64);
				stall_mode = $urandom_range(0, 2);
			end
			pattern_left--;
			if (!arst_n) begin
				m_axis_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (stall_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_basic_ops();
		test_fill_to_capacity();
		send_random_ops(120);
		test_receiver_backpressure();
		send_random_ops(100);
		test_drain_pause();
		send_random_ops(60);
		test_empty_out();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Ran %0d list operations and checked %0d results, including %0d full-list",
			ops_sent, results_checked, full_rejects);
		$display("rejections and %0d out-of-range positions.", bad_positions);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
